// ===== rtl/quaternion_vector_rotate_assert.svh =====
// Assertion macros used by the checker file of the rotation block.
`ifndef QUATERNION_VECTOR_ROTATE_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_ASSERT_SVH

// Checked at every rising edge outside reset.
`define QVR_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("qvr assertion failed");

// Checked at every rising edge, reset included.
`define QVR_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("qvr assertion failed");

`endif

// ===== rtl/qvr_pkg.sv =====
package qvr_pkg;

    localparam int VEC_W   = 32;
    localparam int QUAT_W  = 16;
    localparam int HALF_W  = 16;
    localparam int PROD_W  = 32;
    localparam int TERM_W  = 33;
    localparam int PH_W    = 49;
    localparam int PL_W    = 50;
    localparam int HS_W    = 50;
    localparam int LS_W    = 51;
    localparam int ACC_W   = 67;
    localparam int FRAC_SH = 27;
    localparam int Q_W     = ACC_W - FRAC_SH;
    localparam int STAGES  = 6;
    localparam int DATA_W  = 4 * VEC_W;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef logic signed [VEC_W-1:0]  vec_t;
    typedef logic signed [QUAT_W-1:0] quat_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [PH_W-1:0]   ph_t;
    typedef logic signed [PL_W-1:0]   pl_t;
    typedef logic signed [HS_W-1:0]   hs_t;
    typedef logic signed [LS_W-1:0]   ls_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [Q_W-1:0]    q_t;

    localparam term_t ONE_Q27   = term_t'(134217728);
    localparam acc_t  ROUND_Q43 = acc_t'(67108864);
    localparam quat_t QUAT_ONE  = quat_t'(16384);
    localparam vec_t  SAT_MAX   = 32'sh7FFF_FFFF;
    localparam vec_t  SAT_MIN   = 32'sh8000_0000;

    typedef enum logic [1:0] {
        REG_QUAT_X = 2'd0,
        REG_QUAT_Y = 2'd1,
        REG_QUAT_Z = 2'd2,
        REG_QUAT_W = 2'd3
    } reg_idx_t;

endpackage

// ===== rtl/quaternion_vector_rotate.sv =====
// Each accepted input word passes through six registered stages to the output.
// Throughput: one word per cycle while m_axis_tready holds; a stage moves if its next is free.
// The matrix terms travel with each word, so a register write takes effect on the next word.
// Reset (rst_n low, asynchronous) empties the pipeline and sets the identity quaternion.
module quaternion_vector_rotate
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qvr_pkg::PADDR_W-1:0]   paddr,
    input  logic [qvr_pkg::PDATA_W-1:0]   pwdata,
    output logic [qvr_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // vec_x [31:0], vec_y [63:32], vec_z [95:64], vec_w [127:96]
    input  logic [qvr_pkg::DATA_W-1:0]    s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // rot_x [31:0], rot_y [63:32], rot_z [95:64], pass_w [127:96]
    output logic [qvr_pkg::DATA_W-1:0]    m_axis_tdata
);

    qvr_pkg::quat_t quat_x_reg;
    qvr_pkg::quat_t quat_y_reg;
    qvr_pkg::quat_t quat_z_reg;
    qvr_pkg::quat_t quat_w_reg;
    logic           cfg_wr;

    logic [qvr_pkg::STAGES-1:0] valid_reg;
    logic [qvr_pkg::STAGES-1:0] adv;

    qvr_pkg::vec_t  vec1_reg [3];
    qvr_pkg::vec_t  w1_reg;
    qvr_pkg::prod_t xx1_reg, yy1_reg, zz1_reg, xy1_reg, xz1_reg, yz1_reg;
    qvr_pkg::prod_t wx1_reg, wy1_reg, wz1_reg;

    qvr_pkg::term_t mat_next [3][3];
    qvr_pkg::term_t mat2_reg [3][3];
    qvr_pkg::vec_t  vec2_reg [3];
    qvr_pkg::vec_t  w2_reg;

    qvr_pkg::ph_t   ph_next [3][3];
    qvr_pkg::pl_t   pl_next [3][3];
    qvr_pkg::ph_t   ph3_reg [3][3];
    qvr_pkg::pl_t   pl3_reg [3][3];
    qvr_pkg::vec_t  w3_reg;

    qvr_pkg::hs_t   hs_next [3];
    qvr_pkg::ls_t   ls_next [3];
    qvr_pkg::hs_t   hs4_reg [3];
    qvr_pkg::ls_t   ls4_reg [3];
    qvr_pkg::vec_t  w4_reg;

    qvr_pkg::acc_t  acc_next [3];
    qvr_pkg::q_t    q_next   [3];
    qvr_pkg::q_t    q5_reg   [3];
    qvr_pkg::vec_t  w5_reg;

    qvr_pkg::vec_t  rot_next [3];
    qvr_pkg::vec_t  rot_reg  [3];
    qvr_pkg::vec_t  w6_reg;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_x_reg <= '0;
            quat_y_reg <= '0;
            quat_z_reg <= '0;
            quat_w_reg <= qvr_pkg::QUAT_ONE;
        end
        else if (cfg_wr)
        begin
            case (qvr_pkg::reg_idx_t'(paddr[3:2]))
                qvr_pkg::REG_QUAT_X: quat_x_reg <= qvr_pkg::quat_t'(pwdata[15:0]);
                qvr_pkg::REG_QUAT_Y: quat_y_reg <= qvr_pkg::quat_t'(pwdata[15:0]);
                qvr_pkg::REG_QUAT_Z: quat_z_reg <= qvr_pkg::quat_t'(pwdata[15:0]);
                qvr_pkg::REG_QUAT_W: quat_w_reg <= qvr_pkg::quat_t'(pwdata[15:0]);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (qvr_pkg::reg_idx_t'(paddr[3:2]))
            qvr_pkg::REG_QUAT_X: prdata = {16'd0, quat_x_reg};
            qvr_pkg::REG_QUAT_Y: prdata = {16'd0, quat_y_reg};
            qvr_pkg::REG_QUAT_Z: prdata = {16'd0, quat_z_reg};
            qvr_pkg::REG_QUAT_W: prdata = {16'd0, quat_w_reg};
            default:             prdata = '0;
        endcase
    end

    // A stage loads when it is empty or its contents move on in the same cycle.
    always_comb
    begin
        adv[qvr_pkg::STAGES-1] = !valid_reg[qvr_pkg::STAGES-1] || m_axis_tready;
        for (int i = qvr_pkg::STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign s_axis_tready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < qvr_pkg::STAGES; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Stage 1: capture the word and the quaternion products.
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            vec1_reg[0] <= qvr_pkg::vec_t'(s_axis_tdata[31:0]);
            vec1_reg[1] <= qvr_pkg::vec_t'(s_axis_tdata[63:32]);
            vec1_reg[2] <= qvr_pkg::vec_t'(s_axis_tdata[95:64]);
            w1_reg      <= qvr_pkg::vec_t'(s_axis_tdata[127:96]);
            xx1_reg     <= qvr_pkg::prod_t'(quat_x_reg * quat_x_reg);
            yy1_reg     <= qvr_pkg::prod_t'(quat_y_reg * quat_y_reg);
            zz1_reg     <= qvr_pkg::prod_t'(quat_z_reg * quat_z_reg);
            xy1_reg     <= qvr_pkg::prod_t'(quat_x_reg * quat_y_reg);
            xz1_reg     <= qvr_pkg::prod_t'(quat_x_reg * quat_z_reg);
            yz1_reg     <= qvr_pkg::prod_t'(quat_y_reg * quat_z_reg);
            wx1_reg     <= qvr_pkg::prod_t'(quat_w_reg * quat_x_reg);
            wy1_reg     <= qvr_pkg::prod_t'(quat_w_reg * quat_y_reg);
            wz1_reg     <= qvr_pkg::prod_t'(quat_w_reg * quat_z_reg);
        end
    end

    // Stage 2: rotation matrix terms in units of 2^-27.
    always_comb
    begin
        mat_next[0][0] = qvr_pkg::ONE_Q27 - qvr_pkg::term_t'(yy1_reg)
                         - qvr_pkg::term_t'(zz1_reg);
        mat_next[0][1] = qvr_pkg::term_t'(xy1_reg) - qvr_pkg::term_t'(wz1_reg);
        mat_next[0][2] = qvr_pkg::term_t'(xz1_reg) + qvr_pkg::term_t'(wy1_reg);
        mat_next[1][0] = qvr_pkg::term_t'(xy1_reg) + qvr_pkg::term_t'(wz1_reg);
        mat_next[1][1] = qvr_pkg::ONE_Q27 - qvr_pkg::term_t'(xx1_reg)
                         - qvr_pkg::term_t'(zz1_reg);
        mat_next[1][2] = qvr_pkg::term_t'(yz1_reg) - qvr_pkg::term_t'(wx1_reg);
        mat_next[2][0] = qvr_pkg::term_t'(xz1_reg) - qvr_pkg::term_t'(wy1_reg);
        mat_next[2][1] = qvr_pkg::term_t'(yz1_reg) + qvr_pkg::term_t'(wx1_reg);
        mat_next[2][2] = qvr_pkg::ONE_Q27 - qvr_pkg::term_t'(xx1_reg)
                         - qvr_pkg::term_t'(yy1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            mat2_reg <= mat_next;
            vec2_reg <= vec1_reg;
            w2_reg   <= w1_reg;
        end
    end

    // Stage 3: each term times the signed upper and unsigned lower half of a component.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                ph_next[r][c] = qvr_pkg::ph_t'(mat2_reg[r][c])
                    * qvr_pkg::ph_t'($signed(vec2_reg[c][31:16]));
                pl_next[r][c] = qvr_pkg::pl_t'(mat2_reg[r][c])
                    * qvr_pkg::pl_t'($signed({1'b0, vec2_reg[c][15:0]}));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            ph3_reg <= ph_next;
            pl3_reg <= pl_next;
            w3_reg  <= w2_reg;
        end
    end

    // Stage 4: row sums of the upper and lower partial products.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            hs_next[r] = qvr_pkg::hs_t'(ph3_reg[r][0]) + qvr_pkg::hs_t'(ph3_reg[r][1])
                         + qvr_pkg::hs_t'(ph3_reg[r][2]);
            ls_next[r] = qvr_pkg::ls_t'(pl3_reg[r][0]) + qvr_pkg::ls_t'(pl3_reg[r][1])
                         + qvr_pkg::ls_t'(pl3_reg[r][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            hs4_reg <= hs_next;
            ls4_reg <= ls_next;
            w4_reg  <= w3_reg;
        end
    end

    // Stage 5: combine the halves, round to nearest with ties up, drop 27 fraction bits.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc_next[r] = (qvr_pkg::acc_t'(hs4_reg[r]) <<< qvr_pkg::HALF_W)
                          + qvr_pkg::acc_t'(ls4_reg[r]) + qvr_pkg::ROUND_Q43;
            q_next[r]   = $signed(acc_next[r][qvr_pkg::ACC_W-1:qvr_pkg::FRAC_SH]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            q5_reg <= q_next;
            w5_reg <= w4_reg;
        end
    end

    // Stage 6: saturate into the output register.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            if ((&q5_reg[r][qvr_pkg::Q_W-1:31]) || !(|q5_reg[r][qvr_pkg::Q_W-1:31]))
            begin
                rot_next[r] = $signed(q5_reg[r][31:0]);
            end
            else if (q5_reg[r][qvr_pkg::Q_W-1])
            begin
                rot_next[r] = qvr_pkg::SAT_MIN;
            end
            else
            begin
                rot_next[r] = qvr_pkg::SAT_MAX;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            rot_reg <= rot_next;
            w6_reg  <= w5_reg;
        end
    end

    assign m_axis_tvalid = valid_reg[qvr_pkg::STAGES-1];
    assign m_axis_tdata  = {w6_reg, rot_reg[2], rot_reg[1], rot_reg[0]};

endmodule

// ===== rtl/qvr_checker.sv =====
`include "quaternion_vector_rotate_assert.svh"

module qvr_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [qvr_pkg::DATA_W-1:0]    m_axis_tdata
);

    // A stalled result word stays offered and unchanged.
    `QVR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

    // With the output side taking words, the whole pipeline moves and the input is open.
    `QVR_ASSERT(a_ready_through, m_axis_tready |-> s_axis_tready)

    // A clock edge seen in reset leaves no result word in the pipeline.
    `QVR_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !m_axis_tvalid)

    // After an idle cycle on both sides with the input open, the input is still open.
    `QVR_ASSERT(a_no_early_word, !m_axis_tvalid && !s_axis_tvalid && s_axis_tready && m_axis_tready |=> s_axis_tready)

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (.*);

// ===== test/quaternion_vector_rotate_checker.sv =====
`timescale 1ns / 100ps

module quaternion_vector_rotate_checker
    import qvr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic [PDATA_W-1:0] prdata,
    input  logic               pready,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [DATA_W-1:0]  s_axis_tdata,
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [DATA_W-1:0]  m_axis_tdata,
    output int                 fail_count,
    output int                 rotations_pending
);

    localparam logic signed [63:0]  UNITY_Q27 = 64'sd134217728;
    localparam logic signed [127:0] HALF_Q27  = 128'sd67108864;

    typedef struct {
        vec_t rot_x;
        vec_t rot_y;
        vec_t rot_z;
        vec_t pass_w;
    } rotated_t;

    quat_t    qx;
    quat_t    qy;
    quat_t    qz;
    quat_t    qw;
    rotated_t rotated_q[$];
    int       failures = 0;

    function automatic vec_t rotate_row(input logic signed [63:0] cx, cy, cz,
                                        input vec_t vx, vy, vz);
        logic signed [127:0] ex;
        logic signed [127:0] ey;
        logic signed [127:0] ez;
        logic signed [127:0] ax;
        logic signed [127:0] ay;
        logic signed [127:0] az;
        logic signed [127:0] sum;
        ex = cx;
        ey = cy;
        ez = cz;
        ax = vx;
        ay = vy;
        az = vz;
        // Round to nearest with ties toward plus infinity, then saturate.
        sum = (ex * ax + ey * ay + ez * az + HALF_Q27) >>> FRAC_SH;
        if (sum > SAT_MAX)
            return SAT_MAX;
        if (sum < SAT_MIN)
            return SAT_MIN;
        return sum[31:0];
    endfunction

    function automatic rotated_t predict_rotation(input vec_t vx, vy, vz, vw);
        logic signed [63:0] xx;
        logic signed [63:0] yy;
        logic signed [63:0] zz;
        logic signed [63:0] xy;
        logic signed [63:0] xz;
        logic signed [63:0] yz;
        logic signed [63:0] wx;
        logic signed [63:0] wy;
        logic signed [63:0] wz;
        rotated_t           r;
        xx = qx * qx;
        yy = qy * qy;
        zz = qz * qz;
        xy = qx * qy;
        xz = qx * qz;
        yz = qy * qz;
        wx = qw * qx;
        wy = qw * qy;
        wz = qw * qz;
        r.rot_x  = rotate_row(UNITY_Q27 - yy - zz, xy - wz, xz + wy, vx, vy, vz);
        r.rot_y  = rotate_row(xy + wz, UNITY_Q27 - xx - zz, yz - wx, vx, vy, vz);
        r.rot_z  = rotate_row(xz - wy, yz + wx, UNITY_Q27 - xx - yy, vx, vy, vz);
        r.pass_w = vw;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rotated_t want;
        quat_t    held;
        reg_idx_t idx;
        if (!rst_n)
        begin
            qx = '0;
            qy = '0;
            qz = '0;
            qw = QUAT_ONE;
            rotated_q.delete();
            rotations_pending <= 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                idx = reg_idx_t'(paddr[3:2]);
                case (idx)
                    REG_QUAT_X:
                    begin
                        held = qx;
                        if (pwrite)
                            qx = pwdata[QUAT_W-1:0];
                    end
                    REG_QUAT_Y:
                    begin
                        held = qy;
                        if (pwrite)
                            qy = pwdata[QUAT_W-1:0];
                    end
                    REG_QUAT_Z:
                    begin
                        held = qz;
                        if (pwrite)
                            qz = pwdata[QUAT_W-1:0];
                    end
                    default:
                    begin
                        held = qw;
                        if (pwrite)
                            qw = pwdata[QUAT_W-1:0];
                    end
                endcase
                if (!pwrite)
                    check_field(idx.name(), {16'h0, held}, {16'h0, prdata[QUAT_W-1:0]});
            end
            if (s_axis_tvalid && s_axis_tready)
                rotated_q.push_back(predict_rotation(s_axis_tdata[31:0],
                                                     s_axis_tdata[63:32],
                                                     s_axis_tdata[95:64],
                                                     s_axis_tdata[127:96]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (rotated_q.size() == 0)
                begin
                    $error("output word with no input word pending");
                    failures++;
                end
                else
                begin
                    want = rotated_q.pop_front();
                    check_field("rot_x", want.rot_x, m_axis_tdata[31:0]);
                    check_field("rot_y", want.rot_y, m_axis_tdata[63:32]);
                    check_field("rot_z", want.rot_z, m_axis_tdata[95:64]);
                    check_field("pass_w", want.pass_w, m_axis_tdata[127:96]);
                end
            end
            rotations_pending <= rotated_q.size();
        end
        fail_count <= failures;
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import qvr_pkg::*;

    localparam vec_t  ONE_Q16         = 32'sh0001_0000;
    localparam vec_t  HALF_STEP       = 32'sh0400_0000;
    localparam quat_t QUAT_MIN        = 16'sh8000;
    localparam quat_t QUAT_MAX        = 16'sh7FFF;
    localparam quat_t QUAT_COS45      = 16'sd11585;
    localparam int    LIMIT_CYCLES    = 500000;
    localparam int    RANDOM_PHASES   = 12;
    localparam int    WORDS_PER_PHASE = 125;

    typedef enum logic [1:0] {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_SPARSE,
        SINK_PERIODIC
    } sink_mode_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [DATA_W-1:0]  s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [DATA_W-1:0]  m_axis_tdata;
    int                 fail_count;
    int                 rotations_pending;
    int                 cycle_count = 0;
    int                 burst_left = 0;
    sink_mode_t         sink_mode = SINK_ALWAYS;
    int                 sink_left = 0;
    int                 sink_tick = 0;

    quaternion_vector_rotate DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    quaternion_vector_rotate_checker rotation_check
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .s_axis_tdata      (s_axis_tdata),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .fail_count        (fail_count),
        .rotations_pending (rotations_pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (sink_left == 0)
        begin
            sink_mode = sink_mode_t'($urandom_range(0, 3));
            sink_left = $urandom_range(20, 200);
        end
        sink_left--;
        sink_tick++;
        case (sink_mode)
            SINK_ALWAYS:   m_axis_tready <= 1'b1;
            SINK_RANDOM:   m_axis_tready <= $urandom_range(0, 1);
            SINK_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
            SINK_PERIODIC: m_axis_tready <= ((sink_tick % 7) < 4);
        endcase
    end

    // Back-to-back accesses keep psel high; the caller returns the bus to idle.
    task automatic apb_access(input reg_idx_t idx, input logic write_en, input quat_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_en;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (rotations_pending != 0)
            @(posedge clk);
        repeat (STAGES + 2)
            @(posedge clk);
    endtask

    task automatic load_quat(input quat_t qx, qy, qz, qw, input logic [3:0] write_mask);
        quat_t vals[4];
        drain();
        vals = '{qx, qy, qz, qw};
        for (int i = 0; i < 4; i++)
            if (write_mask[i])
                apb_access(reg_idx_t'(i), 1'b1, vals[i]);
        for (int i = 0; i < 4; i++)
            apb_access(reg_idx_t'(i), 1'b0, '0);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_vec(input vec_t vx, vy, vz, vw);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {vw, vz, vy, vx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
    endtask

    function automatic vec_t rand_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return vec_t'($urandom);
            9:
            begin
                case ($urandom_range(0, 3))
                    0:       return SAT_MAX;
                    1:       return SAT_MIN;
                    2:       return '0;
                    default: return -32'sd1;
                endcase
            end
            default: return vec_t'($urandom_range(0, 2097151)) - 32'sd1048576;
        endcase
    endfunction

    function automatic quat_t rand_quat();
        case ($urandom_range(0, 5))
            0:       return quat_t'($urandom);
            1:       return QUAT_MIN;
            2:       return QUAT_MAX;
            3:       return '0;
            default: return quat_t'($urandom_range(0, 23170)) - 16'sd11585;
        endcase
    endfunction

    task automatic send_random_vec();
        vec_t vx;
        vec_t vy;
        vec_t vz;
        vec_t vw;
        int   kind;
        kind = $urandom_range(0, 9);
        vx = rand_coord();
        vy = rand_coord();
        vz = (kind < 3) ? '0 : rand_coord();
        vw = (kind < 5) ? ONE_Q16 : vec_t'($urandom);
        send_vec(vx, vy, vz, vw);
    endtask

    initial
    begin
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        load_quat('0, '0, '0, '0, 4'b0000);
        send_vec('0, '0, '0, '0);
        send_vec(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
        send_vec(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
        send_vec(-32'sd1, 32'sd1, '0, ONE_Q16);
        send_vec(32'sh0003_0000, -32'sh0002_0000, ONE_Q16, ONE_Q16);

        // A unit z and w term puts rounding ties on the rows.
        load_quat('0, '0, 16'sd1, 16'sd1, 4'b1111);
        send_vec('0, HALF_STEP, '0, '0);
        send_vec('0, -HALF_STEP, '0, '0);
        send_vec(HALF_STEP, '0, -HALF_STEP, -32'sd1);

        load_quat('0, '0, QUAT_COS45, QUAT_COS45, 4'b1111);
        send_vec(ONE_Q16, '0, '0, ONE_Q16);
        send_vec(32'sh0005_0000, 32'sh0003_0000, '0, ONE_Q16);
        send_vec(SAT_MAX, '0, '0, '0);

        load_quat(QUAT_MIN, QUAT_MIN, QUAT_MIN, QUAT_MIN, 4'b1111);
        send_vec(SAT_MAX, SAT_MIN, SAT_MAX, 32'sh5555_5555);
        send_vec(ONE_Q16, ONE_Q16, ONE_Q16, 32'shAAAA_AAAA);
        send_vec(SAT_MIN, SAT_MIN, SAT_MIN, '0);

        load_quat(QUAT_MAX, QUAT_MAX, QUAT_MAX, QUAT_MAX, 4'b1111);
        send_vec(SAT_MAX, SAT_MAX, SAT_MAX, -32'sd1);
        send_vec(32'sd1, -32'sd1, 32'sd1, '0);

        load_quat(QUAT_MIN, '0, '0, '0, 4'b1111);
        send_vec(SAT_MIN, SAT_MAX, SAT_MIN, SAT_MIN);
        send_vec(32'sd12345, -32'sd67890, '0, ONE_Q16);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            load_quat(rand_quat(), rand_quat(), rand_quat(), rand_quat(), 4'($urandom));
            repeat (WORDS_PER_PHASE)
                send_random_vec();
        end

        drain();
        @(posedge clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/qvr_pkg.sv
rtl/quaternion_vector_rotate.sv
rtl/qvr_checker.sv
test/quaternion_vector_rotate_checker.sv
test/testbench.sv
